// ===== rtl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants and payload types of the longest-subarray-with-sum block.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int ELEM_W      = 16;
    localparam int TARGET_W    = 27;
    localparam int LEN_W       = 11;
    localparam int MAX_LEN_DEF = 1024;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     is_last;
    } t_item;

    typedef struct packed {
        logic [LEN_W-1:0] longest_len;
        logic             overflowed;
    } t_result;

endpackage

// ===== rtl/lss_fifo.sv =====
// ----------------------------------------------------------------------------
// lss_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module lss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/lss_front.sv =====
// ----------------------------------------------------------------------------
// lss_front
// Accepts elements, keeps the running prefix sum and index, and classifies
// each element into a table job for the back end.
// ----------------------------------------------------------------------------
module lss_front import lss_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int SUM_W   = 29
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  t_item                                 i_item,
    input  logic signed [TARGET_W-1:0]            i_target,
    output logic [2*SUM_W+$clog2(MAX_LEN)+3:0]    o_job
);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_too_long;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] w_elem;
    logic signed [SUM_W-1:0] w_tgt;
    logic signed [SUM_W-1:0] w_diff;
    logic                    w_live;
    logic                    w_hit;
    logic                    w_ovf;

    assign w_elem = SUM_W'(signed'(i_item.element[VALUE_BITS-1:0]));
    assign w_tgt  = SUM_W'(i_target);
    assign w_live = (r_idx != CNT_W'(MAX_LEN));
    assign n_sum  = r_sum + w_elem;
    assign w_diff = n_sum - w_tgt;
    assign w_hit  = (n_sum == w_tgt);
    assign w_ovf  = r_too_long || !w_live;
    assign o_job  = {w_diff, n_sum, r_idx[IDX_W-1:0], w_live, w_hit,
                     i_item.is_last, w_ovf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_idx      <= '0;
            r_too_long <= 1'b0;
        end else if (i_accept) begin
            if (i_item.is_last) begin
                r_sum      <= '0;
                r_idx      <= '0;
                r_too_long <= 1'b0;
            end else if (w_live) begin
                r_sum <= n_sum;
                r_idx <= r_idx + 1'b1;
            end else begin
                r_too_long <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/lss_back.sv =====
// ----------------------------------------------------------------------------
// lss_back
// Runs each job against the prefix table: scans the table one entry per
// cycle, tracks the longest length, inserts new prefixes, emits results.
// ----------------------------------------------------------------------------
module lss_back import lss_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int SUM_W   = 29
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [2*SUM_W+$clog2(MAX_LEN)+3:0]    i_job,
    input  logic                                  i_job_empty,
    output logic                                  o_job_pop,
    input  logic                                  i_out_full,
    output logic                                  o_out_push,
    output t_result                               o_result
);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    t_state           r_state;
    logic [SUM_W-1:0] r_diff;
    logic [SUM_W-1:0] r_sum;
    logic [IDX_W-1:0] r_idx;
    logic             r_live;
    logic             r_last;
    logic             r_ovf;
    logic [CNT_W-1:0] r_best;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_ptr;
    logic             r_pend;
    logic             r_seen;

    logic [SUM_W-1:0] r_mem_val [MAX_LEN];
    logic [IDX_W-1:0] r_mem_idx [MAX_LEN];
    logic [SUM_W-1:0] r_rd_val;
    logic [IDX_W-1:0] r_rd_idx;

    logic [SUM_W-1:0] w_j_diff;
    logic [SUM_W-1:0] w_j_sum;
    logic [IDX_W-1:0] w_j_idx;
    logic             w_j_live;
    logic             w_j_hit;
    logic             w_j_last;
    logic             w_j_ovf;
    logic [CNT_W-1:0] w_j_len;
    logic [CNT_W-1:0] w_scan_len;
    logic             w_fin_go;
    logic             w_wr_en;

    assign {w_j_diff, w_j_sum, w_j_idx, w_j_live, w_j_hit, w_j_last, w_j_ovf} = i_job;
    assign w_j_len    = CNT_W'(w_j_idx) + 1'b1;
    assign w_scan_len = CNT_W'(r_idx) - CNT_W'(r_rd_idx);
    assign o_job_pop  = (r_state == S_IDLE) && !i_job_empty;
    assign w_fin_go   = !(r_last && i_out_full);
    assign w_wr_en    = (r_state == S_FIN) && w_fin_go && r_live && !r_seen
                        && (r_cnt < CNT_W'(MAX_LEN));
    assign o_out_push = (r_state == S_FIN) && w_fin_go && r_last;
    assign o_result   = '{longest_len: LEN_W'(r_best), overflowed: r_ovf};

    // table storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_val[r_cnt[IDX_W-1:0]] <= r_sum;
            r_mem_idx[r_cnt[IDX_W-1:0]] <= r_idx;
        end
        r_rd_val <= r_mem_val[r_ptr[IDX_W-1:0]];
        r_rd_idx <= r_mem_idx[r_ptr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_best  <= '0;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_pend  <= 1'b0;
            r_seen  <= 1'b0;
            r_live  <= 1'b0;
            r_last  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_diff <= w_j_diff;
                        r_sum  <= w_j_sum;
                        r_idx  <= w_j_idx;
                        r_live <= w_j_live;
                        r_last <= w_j_last;
                        r_ovf  <= w_j_ovf;
                        r_ptr  <= '0;
                        r_pend <= 1'b0;
                        r_seen <= 1'b0;
                        if (w_j_live && w_j_hit && (w_j_len > r_best)) begin
                            r_best <= w_j_len;
                        end
                        r_state <= w_j_live ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    if (r_pend) begin
                        if ((r_rd_val == r_diff) && (w_scan_len > r_best)) begin
                            r_best <= w_scan_len;
                        end
                        if (r_rd_val == r_sum) begin
                            r_seen <= 1'b1;
                        end
                    end
                    if (r_ptr < r_cnt) begin
                        r_ptr  <= r_ptr + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        if (w_wr_en) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (r_last) begin
                            r_best <= '0;
                            r_cnt  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/longest_subarray_with_sum_top.sv =====
// Per element: the back end passes through idle, scan and finish states; the scan
// covers the distinct prefix sums stored so far in this array and is skipped
// past the length limit; the table is scanned one entry per cycle over its
// single read port. The last element's result is pushed once the result queue
// has room. Up to two elements and two results may wait in queues.
// Synchronous active-low reset clears sums, counters and queues, not the table.
// ----------------------------------------------------------------------------
// longest_subarray_with_sum_top
// Streams array elements and reports the longest subarray reaching the
// programmed target sum, using a prefix-sum table with first indexes.
// ----------------------------------------------------------------------------
module longest_subarray_with_sum_top import lss_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // element queue side
    input  logic                       push,
    output logic                       full,
    input  t_item                      i_item,
    // result queue side
    output logic                       empty,
    input  logic                       pop,
    output t_result                    o_result,
    // target register write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic signed [TARGET_W-1:0] i_cfg_data
);
    // sum wide enough for the prefix and for prefix minus target
    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int RAW_W  = (VALUE_BITS + CNT_W + 1 > TARGET_W)
                            ? VALUE_BITS + CNT_W + 1 : TARGET_W;
    localparam int SUM_W  = RAW_W + 1;
    localparam int JOB_W  = 2 * SUM_W + IDX_W + 4;

    logic signed [TARGET_W-1:0] r_target;
    logic                       w_accept;
    logic [JOB_W-1:0]           w_job_in;
    logic [JOB_W-1:0]           w_job_out;
    logic                       w_job_empty;
    logic                       w_job_pop;
    logic                       w_out_full;
    logic                       w_out_push;
    t_result                    w_result;
    logic [$bits(t_result)-1:0] w_res_q;

    // the user must write the target only while idle; the block does not enforce this and always takes the transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (cfg_valid) begin
            r_target <= i_cfg_data;
        end
    end

    // an element transfer happens whenever push is high and the job queue has room
    assign w_accept = push && !full;

    lss_front #(.MAX_LEN(MAX_LEN), .SUM_W(SUM_W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .i_target (r_target),
        .o_job    (w_job_in)
    );

    // job queue decouples classification from the table scan
    lss_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_job_in),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_full  (full),
        .o_empty (w_job_empty)
    );

    lss_back #(.MAX_LEN(MAX_LEN), .SUM_W(SUM_W)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_result    (w_result)
    );

    // result queue: hold finished results until popped
    lss_fifo #(.WIDTH($bits(t_result)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_result),
        .i_pop   (pop),
        .o_data  (w_res_q),
        .o_full  (w_out_full),
        .o_empty (empty)
    );

    assign o_result = t_result'(w_res_q);

endmodule

// ===== tb/longest_subarray_with_sum_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_subarray_with_sum_top_tb
// Streams arrays of signed elements into the block, predicts the longest
// subarray length per array with a prefix-sum table of its own, and checks
// every result against it under random idling on both sides.
// ----------------------------------------------------------------------------
module longest_subarray_with_sum_top_tb;
    import lss_pkg::*;

    localparam int MAX_LEN    = MAX_LEN_DEF;
    localparam int WDOG_LIMIT = 200000;
    localparam int HOLD_CYC   = 400;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    t_item                      i_item = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    t_result                    o_result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic signed [TARGET_W-1:0] i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    longest_subarray_with_sum_top #(.MAX_LEN(MAX_LEN)) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Prediction: running prefix sum plus table of first indexes
    // ------------------------------------------------------------------
    logic signed [TARGET_W-1:0] tgt_sum;
    longint                     pre_sum;
    int                         elem_cnt;
    int                         best_len;
    bit                         too_long;
    int                         first_idx [longint];
    t_result                    len_exp_q [$];

    function automatic void clear_array();
        pre_sum  = 0;
        elem_cnt = 0;
        best_len = 0;
        too_long = 1'b0;
        first_idx.delete();
    endfunction

    function automatic void predict_len(t_item it);
        longint  tgt;
        t_result r;
        tgt = tgt_sum;
        if (elem_cnt >= MAX_LEN) begin
            too_long = 1'b1;
        end else begin
            pre_sum += it.element;
            if (pre_sum == tgt && elem_cnt + 1 > best_len) best_len = elem_cnt + 1;
            if (first_idx.exists(pre_sum - tgt) &&
                elem_cnt - first_idx[pre_sum - tgt] > best_len)
                best_len = elem_cnt - first_idx[pre_sum - tgt];
            if (!first_idx.exists(pre_sum)) first_idx[pre_sum] = elem_cnt;
            elem_cnt++;
        end
        if (it.is_last) begin
            r.longest_len = best_len[LEN_W-1:0];
            r.overflowed  = too_long;
            len_exp_q.insert(len_exp_q.size(), r);
            clear_array();
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: drain the pending-element queue
    // ------------------------------------------------------------------
    t_item elem_q [$];
    bit    drive_on = 1'b0;
    bit    no_idle  = 1'b0;

    always @(posedge i_clk) begin
        if (push && !full) begin
            predict_len(i_item);
        end
        // hold the offer until a transfer happens
        if (!(push && full)) begin
            if (drive_on && elem_q.size() > 0 &&
                (no_idle || $urandom_range(99) >= 21)) begin
                i_item <= elem_q.pop_front();
                push   <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver hold-off: counts its own cycles once requested
    // ------------------------------------------------------------------
    bit hold_go = 1'b0;
    bit hold_on = 1'b0;

    initial begin
        wait (hold_go);
        hold_on = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_on = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: random pop, long hold-off on request
    // ------------------------------------------------------------------
    int errors   = 0;
    int rcv_cnt  = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s result %0d: got %0d want %0d", what, rcv_cnt, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (pop && !empty) begin
            if (len_exp_q.size() == 0) begin
                report_mismatch("unexpected", 1, 0);
            end else begin
                want = len_exp_q.pop_front();
                if (o_result.longest_len !== want.longest_len)
                    report_mismatch("longest_len", o_result.longest_len, want.longest_len);
                if (o_result.overflowed !== want.overflowed)
                    report_mismatch("overflowed", o_result.overflowed, want.overflowed);
            end
            rcv_cnt <= rcv_cnt + 1;
        end
        if (hold_on) begin
            pop <= 1'b0;
        end else begin
            pop <= no_idle || $urandom_range(99) >= 21;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any transfer
    // ------------------------------------------------------------------
    int idle_cyc = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !drive_on)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cyc);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return ELEM_W'($urandom_range(8) - 4);
            5, 6:    return ELEM_W'($urandom_range(64) - 32);
            default: return ELEM_W'($urandom());
        endcase
    endfunction

    task automatic add_array(int len, bit rnd, logic signed [ELEM_W-1:0] fixed);
        t_item it;
        for (int k = 0; k < len; k++) begin
            it.element = rnd ? rand_elem() : fixed;
            it.is_last = (k == len - 1);
            elem_q.insert(elem_q.size(), it);
        end
    endtask

    // wait for everything queued to drain, then for the block to settle
    task automatic drain();
        while (elem_q.size() != 0 || push) @(posedge i_clk);
        while (len_exp_q.size() != 0) @(posedge i_clk);
        repeat (MAX_LEN + 20) @(posedge i_clk);
    endtask

    task automatic write_target(logic signed [TARGET_W-1:0] v);
        @(posedge i_clk);
        cfg_valid  <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tgt_sum = v;
    endtask

    initial begin
        logic signed [TARGET_W-1:0] tgts [6];
        tgt_sum = '0;
        clear_array();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drive_on = 1'b1;

        // directed: reset target 0, extremes, a single-element array
        add_array(1, 0, 16'sh0000);
        add_array(3, 0, 16'sh7FFF);
        add_array(3, 0, 16'sh8000);
        add_array(4, 0, 16'sh0001);
        add_array(4, 0, -16'sh0001);
        drain();
        write_target(27'sh3FFFFFF);            // max positive
        add_array(3, 0, 16'sh7FFF);
        drain();
        write_target(-27'sh4000000);           // most negative
        add_array(3, 0, 16'sh8000);
        drain();
        write_target(27'sd3);
        add_array(6, 0, 16'sh0001);
        drain();
        // too many elements: longest array, then extra ones
        write_target(27'sd0);
        add_array(MAX_LEN + 2, 0, 16'sh0000);
        drain();

        // long hold-off at the receiver while the sender keeps offering
        hold_go = 1'b1;
        for (int a = 0; a < 8; a++) add_array(2, 1, '0);
        drain();

        // random arrays over several target settings
        tgts = '{27'sd0, 27'sd5, -27'sd7, 27'sd32767, 27'sd1, -27'sd32768};
        for (int ph = 0; ph < 6; ph++) begin
            write_target(tgts[ph]);
            no_idle = (ph == 2);
            for (int a = 0; a < 4; a++) begin
                int len;
                len = ($urandom_range(19) == 0) ? $urandom_range(40) + 1
                                                : $urandom_range(8) + 1;
                add_array(len, 1, '0);
            end
            drain();
        end
        no_idle = 1'b0;

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
